@@ hw/rtl/sbsm_pkg.sv @@
package sbsm_pkg;

  localparam int unsigned WORK_RAM_BYTES_DEF = 8192;

  localparam int unsigned BANK_CNT_W = 5;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned RAM_OFS_W  = 13;
  localparam int unsigned MADDR_W    = 18;

  typedef enum logic [1:0] {
    CMD_CPU_RD = 2'd0,
    CMD_CPU_WR = 2'd1,
    CMD_PPU_RD = 2'd2,
    CMD_PPU_WR = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRG_BANKS = 1'b0,
    CFG_CHR_BANKS = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    TGT_CONTROL  = 2'd0,
    TGT_CHR_LOW  = 2'd1,
    TGT_CHR_HIGH = 2'd2,
    TGT_PRG      = 2'd3
  } target_t;

  typedef enum logic [1:0] {
    PRG_32K_A    = 2'd0,
    PRG_32K_B    = 2'd1,
    PRG_FIX_LOW  = 2'd2,
    PRG_FIX_HIGH = 2'd3
  } prg_mode_t;

  localparam logic [4:0] CONTROL_RESET = 5'h1C;
  localparam logic [4:0] CONTROL_RESET_OR = 5'h0C;
  localparam logic [2:0] SHIFT_FULL = 3'd5;

  typedef struct packed {
    logic               hit;
    logic               ram_hit;
    logic               ram_rd;
    logic [MADDR_W-1:0] mem_offset;
    logic [1:0]         mirroring;
  } map_res_t;

  typedef struct packed {
    logic                 rd;
    logic                 wr;
    logic [RAM_OFS_W-1:0] ofs;
    logic [7:0]           data;
  } ram_req_t;

endpackage

@@ hw/rtl/sbsm_if.sv @@
interface sbsm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] bus_addr;
  logic [7:0]  wr_data;

  modport source (output valid, cmd, bus_addr, wr_data, input ready);
  modport sink (input valid, cmd, bus_addr, wr_data, output ready);
endinterface

interface sbsm_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic        ram_hit;
  logic [17:0] mem_offset;
  logic [7:0]  rd_data;
  logic [1:0]  mirroring;

  modport source (output valid, hit, ram_hit, mem_offset, rd_data, mirroring,
                  input ready);
  modport sink (input valid, hit, ram_hit, mem_offset, rd_data, mirroring,
                output ready);
endinterface

@@ hw/rtl/sbsm_map.sv @@
module sbsm_map import sbsm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [BANK_CNT_W-1:0] cfg_data,
  input  logic                  accept,
  input  logic [1:0]            cmd,
  input  logic [15:0]           bus_addr,
  input  logic [7:0]            wr_data,
  output map_res_t              res,
  output ram_req_t              ram_req
);

  logic [BANK_CNT_W-1:0] prg_bank_count;
  logic [BANK_CNT_W-1:0] chr_bank_count;
  logic [4:0] shift_value, shift_value_next;
  logic [2:0] shift_count, shift_count_next;
  logic [4:0] control_bits, control_bits_next;
  logic [4:0] pattern_bank_low, pattern_bank_low_next;
  logic [4:0] pattern_bank_high, pattern_bank_high_next;
  logic [4:0] program_bank, program_bank_next;

  logic [4:0] shifted;
  logic [2:0] count_inc;
  logic       ram_region;
  logic       ppu_region;
  logic [3:0] last_bank;
  logic [3:0] prg_sel;
  logic [MADDR_W-1:0] prg_addr;
  logic [MADDR_W-1:0] chr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank_count <= BANK_CNT_W'(2);
      chr_bank_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PRG_BANKS: prg_bank_count <= cfg_data;
        CFG_CHR_BANKS: chr_bank_count <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ram_region = (bus_addr[15:13] == 3'b011);
  assign ppu_region = (bus_addr[15:13] == 3'b000);
  assign shifted    = {wr_data[0], shift_value[4:1]};
  assign count_inc  = shift_count + 3'd1;

  always_comb begin
    shift_value_next       = shift_value;
    shift_count_next       = shift_count;
    control_bits_next      = control_bits;
    pattern_bank_low_next  = pattern_bank_low;
    pattern_bank_high_next = pattern_bank_high;
    program_bank_next      = program_bank;
    if (accept && cmd_t'(cmd) == CMD_CPU_WR && bus_addr[15]) begin
      priority if (wr_data[7]) begin
        shift_value_next  = '0;
        shift_count_next  = '0;
        control_bits_next = control_bits | CONTROL_RESET_OR;
      end else if (count_inc == SHIFT_FULL) begin
        shift_value_next = '0;
        shift_count_next = '0;
        unique case (target_t'(bus_addr[14:13]))
          TGT_CONTROL:  control_bits_next      = shifted;
          TGT_CHR_LOW:  pattern_bank_low_next  = shifted;
          TGT_CHR_HIGH: pattern_bank_high_next = shifted;
          TGT_PRG:      program_bank_next      = shifted;
          default: ;
        endcase
      end else begin
        shift_value_next = shifted;
        shift_count_next = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_value       <= '0;
      shift_count       <= '0;
      control_bits      <= CONTROL_RESET;
      pattern_bank_low  <= '0;
      pattern_bank_high <= '0;
      program_bank      <= '0;
    end else begin
      shift_value       <= shift_value_next;
      shift_count       <= shift_count_next;
      control_bits      <= control_bits_next;
      pattern_bank_low  <= pattern_bank_low_next;
      pattern_bank_high <= pattern_bank_high_next;
      program_bank      <= program_bank_next;
    end
  end

  // a prg_bank_count of zero wraps to bank 15
  assign last_bank = 4'(prg_bank_count - BANK_CNT_W'(1));

  always_comb begin
    prg_sel  = program_bank[3:0];
    prg_addr = '0;
    unique case (prg_mode_t'(control_bits[3:2]))
      PRG_32K_A, PRG_32K_B: prg_addr = {program_bank[3:1], bus_addr[14:0]};
      PRG_FIX_LOW: begin
        prg_sel  = bus_addr[14] ? program_bank[3:0] : 4'd0;
        prg_addr = {prg_sel, bus_addr[13:0]};
      end
      PRG_FIX_HIGH: begin
        prg_sel  = bus_addr[14] ? last_bank : program_bank[3:0];
        prg_addr = {prg_sel, bus_addr[13:0]};
      end
      default: ;
    endcase
  end

  always_comb begin
    priority if (chr_bank_count == '0) begin
      chr_addr = {5'd0, bus_addr[12:0]};
    end else if (!control_bits[4]) begin
      chr_addr = {1'b0, pattern_bank_low[4:1], bus_addr[12:0]};
    end else if (!bus_addr[12]) begin
      chr_addr = {1'b0, pattern_bank_low, bus_addr[11:0]};
    end else begin
      chr_addr = {1'b0, pattern_bank_high, bus_addr[11:0]};
    end
  end

  always_comb begin
    res           = '0;
    res.mirroring = control_bits_next[1:0];
    unique case (cmd_t'(cmd))
      CMD_CPU_RD: begin
        if (ram_region) begin
          res.hit     = 1'b1;
          res.ram_hit = 1'b1;
          res.ram_rd  = 1'b1;
        end else if (bus_addr[15]) begin
          res.hit        = 1'b1;
          res.mem_offset = prg_addr;
        end
      end
      CMD_CPU_WR: begin
        if (ram_region) begin
          res.hit     = 1'b1;
          res.ram_hit = 1'b1;
        end
      end
      CMD_PPU_RD: begin
        if (ppu_region) begin
          res.hit        = 1'b1;
          res.mem_offset = chr_addr;
        end
      end
      CMD_PPU_WR: begin
        if (ppu_region && chr_bank_count == '0) begin
          res.hit        = 1'b1;
          res.mem_offset = {5'd0, bus_addr[12:0]};
        end
      end
      default: ;
    endcase
  end

  assign ram_req.rd   = accept && ram_region && cmd_t'(cmd) == CMD_CPU_RD;
  assign ram_req.wr   = accept && ram_region && cmd_t'(cmd) == CMD_CPU_WR;
  assign ram_req.ofs  = bus_addr[RAM_OFS_W-1:0];
  assign ram_req.data = wr_data;

endmodule

@@ hw/rtl/sbsm_wram.sv @@
module sbsm_wram import sbsm_pkg::*; #(
  parameter int unsigned RAM_BYTES = WORK_RAM_BYTES_DEF
) (
  input  logic     clk,
  input  ram_req_t req,
  output logic [7:0] rd_data
);

  localparam int unsigned AW = $clog2(RAM_BYTES);

  logic [7:0]    mem [RAM_BYTES];
  logic [17:0]   ofs_red;
  logic [AW-1:0] idx;

  // offset modulo depth; offset < 8192 and depth >= 1024 so three folds suffice
  always_comb begin
    ofs_red = 18'(req.ofs);
    for (int i = 2; i >= 0; i--) begin
      if (ofs_red >= 18'(RAM_BYTES << i)) begin
        ofs_red = ofs_red - 18'(RAM_BYTES << i);
      end
    end
  end

  assign idx = ofs_red[AW-1:0];

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[idx] <= req.data;
    end
    if (req.rd) begin
      rd_data <= mem[idx];
    end
  end

endmodule

@@ hw/rtl/serial_loaded_bank_switch_mapper.sv @@
// An accepted transaction is held in s1, then registered into s2 and presented on rsp.
// Throughput: one transaction per cycle while rsp is not stalled; the work RAM has
//   one port, read or written at most once per transaction, with registered read data.
// Reset (rst, synchronous): load register and bank registers cleared,
//   control 0x1C, bank counts 2 and 0, pipeline emptied; work RAM not cleared.
module serial_loaded_bank_switch_mapper import sbsm_pkg::*; #(
  parameter int unsigned WORK_RAM_BYTES = WORK_RAM_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [BANK_CNT_W-1:0] cfg_data,
  sbsm_req_if.sink              req,
  sbsm_rsp_if.source            rsp
);

  map_res_t   map_res;
  ram_req_t   ram_req;
  logic [7:0] ram_q;
  logic       accept;

  logic       s1_valid;
  map_res_t   s1_res;
  logic       s2_valid;
  logic       s2_load;

  assign s2_load   = s1_valid && (!s2_valid || rsp.ready);
  assign req.ready = !s1_valid || s2_load;
  assign accept    = req.valid && req.ready;

  sbsm_map u_map (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .cmd       (req.cmd),
    .bus_addr  (req.bus_addr),
    .wr_data   (req.wr_data),
    .res       (map_res),
    .ram_req   (ram_req)
  );

  sbsm_wram #(
    .RAM_BYTES (WORK_RAM_BYTES)
  ) u_wram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s2_load) begin
        s1_valid <= 1'b0;
      end
      if (s2_load) begin
        s2_valid <= 1'b1;
      end else if (rsp.ready) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res <= map_res;
    end
    if (s2_load) begin
      rsp.hit        <= s1_res.hit;
      rsp.ram_hit    <= s1_res.ram_hit;
      rsp.mem_offset <= s1_res.mem_offset;
      rsp.rd_data    <= s1_res.ram_rd ? ram_q : 8'd0;
      rsp.mirroring  <= s1_res.mirroring;
    end
  end

  assign rsp.valid = s2_valid;

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted transaction not held in first stage");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s2_valid && !rsp.ready |-> !req.ready)
    else $error("transaction accepted with both stages stalled");

  a_rd_data_only_on_ram: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.rd_data != 8'd0 |-> rsp.ram_hit)
    else $error("read data outside work RAM");

  a_ram_hit_implies_hit: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_res.ram_hit |-> s1_res.hit)
    else $error("work RAM access not claimed");

endmodule
